@@ design/wtc_pkg.sv @@
// Shared types and constants of the wildcard token classifier.
package wtc_pkg;

  localparam int CFG_W   = 5;
  localparam int DIGIT_W = 5;

  localparam logic [CFG_W-1:0]   MAX_INT_RESET   = 5'd19;
  localparam logic [CFG_W-1:0]   MAX_FLOAT_RESET = 5'd16;
  localparam logic [DIGIT_W-1:0] DIGIT_SAT       = '1;

  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_Z   = 8'h7A;

  typedef enum logic [0:0] {
    REG_MAX_INT_DIGITS   = 1'b0,
    REG_MAX_FLOAT_DIGITS = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_first;
    logic       is_last;
    logic       after_equals;
  } token_t;

  typedef struct packed {
    logic       maybe_integer;
    logic       maybe_float;
    logic       maybe_static_text;
    logic       maybe_dictionary;
    logic       starts_with_star;
    logic       ends_with_star;
    logic [2:0] interpretation_count;
  } result_t;

endpackage

@@ design/wtc_ifs.sv @@
// Valid/ready channel interfaces for token characters and classification results.
interface wtc_tok_if;
  logic            valid;
  logic            ready;
  wtc_pkg::token_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wtc_res_if;
  logic             valid;
  logic             ready;
  wtc_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/wildcard_token_classifier.sv @@
// Top level of the wildcard token classifier.
//
// Usage: a query token streams in on the token channel, one character per
// transaction, with is_first marking its first character and is_last its
// last. A character that arrives while no token is open also starts one.
// Only the last character of a token produces a transaction on the result
// channel; it lists which interpretations (integer, float, static text,
// dictionary variable) are possible, the leading and trailing '*' flags and
// the interpretation count.
// A character is captured in an input register, then classified by a few
// gates and the digit counter into the result register that offers results.
// Throughput: one character per cycle, unless a last character is stalled;
// each character updates the token flags and the saturating digit counter.
// When the receiver stalls with a result pending, characters that produce no
// result keep flowing; a last character waits in the input register until
// the result register frees, and the token channel stops taking data.
// The user must write the digit limits through cfg_write/cfg_index/cfg_data
// only while the block is idle; the block itself does not enforce this.
// Reset (synchronous, rst high) restores the limits to 19 integer and 16
// float digits, closes any open token and drops results.
module wildcard_token_classifier (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  wtc_pkg::reg_index_t           cfg_index,
  input  logic [wtc_pkg::CFG_W-1:0]     cfg_data,
  wtc_tok_if.sink                       token,
  wtc_res_if.source                     result
);
  import wtc_pkg::*;

  // Per-token running state.
  typedef struct packed {
    logic               int_alive;
    logic               float_alive;
    logic               static_alive;
    logic               seen_minus;
    logic               seen_dot;
    logic [DIGIT_W-1:0] digit_count;
    logic               escape_pending;
    logic               has_letter;
    logic               first_is_question;
    logic               first_is_star;
    logic               equals_before;
    logic               in_token;
  } tok_state_t;

  localparam tok_state_t STATE_CLEAR = '{
    int_alive: 1'b1, float_alive: 1'b1, static_alive: 1'b1,
    seen_minus: 1'b0, seen_dot: 1'b0, digit_count: '0,
    escape_pending: 1'b0, has_letter: 1'b0, first_is_question: 1'b0,
    first_is_star: 1'b0, equals_before: 1'b0, in_token: 1'b0
  };

  logic [CFG_W-1:0] max_int_digits;
  logic [CFG_W-1:0] max_float_digits;

  // Input register stage.
  logic   in_valid;
  token_t in_data;

  // Output register stage.
  logic    out_valid;
  result_t out_data;

  tok_state_t state;
  tok_state_t state_next;
  tok_state_t base;
  result_t    res_next;

  logic in_advance;
  logic out_free;
  logic tok_start;
  logic is_digit;
  logic is_alpha;
  logic [DIGIT_W-1:0] count_inc;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_int_digits   <= MAX_INT_RESET;
      max_float_digits <= MAX_FLOAT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAX_INT_DIGITS:   max_int_digits   <= cfg_data;
        REG_MAX_FLOAT_DIGITS: max_float_digits <= cfg_data;
        default: ;
      endcase
    end
  end

  // A character with no result always moves on; a last character needs a
  // free result register, either empty or being emptied this cycle.
  assign out_free    = !out_valid || result.ready;
  assign in_advance  = in_valid && (!in_data.is_last || out_free);
  assign token.ready = !in_valid || in_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (token.ready) begin
      in_valid <= token.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (token.valid && token.ready) begin
      in_data <= token.data;
    end
  end

  // Classification of the registered character against the token state.
  always_comb begin
    tok_start = in_data.is_first || !state.in_token;
    is_digit  = (in_data.char_code >= CH_ZERO) && (in_data.char_code <= CH_NINE);
    is_alpha  = ((in_data.char_code >= CH_UPPER_A) && (in_data.char_code <= CH_UPPER_Z)) ||
                ((in_data.char_code >= CH_LOWER_A) && (in_data.char_code <= CH_LOWER_Z));

    // A new token begins from the cleared state and latches its leading flags.
    base = state;
    if (tok_start) begin
      base                   = STATE_CLEAR;
      base.first_is_question = (in_data.char_code == CH_QUESTION);
      base.first_is_star     = (in_data.char_code == CH_STAR);
      base.equals_before     = in_data.after_equals;
      base.in_token          = 1'b1;
    end

    state_next = base;
    count_inc  = (base.digit_count == DIGIT_SAT) ? DIGIT_SAT
                                                 : base.digit_count + DIGIT_W'(1);

    // Numeric interpretations.
    if (in_data.char_code == CH_DOT) begin
      state_next.int_alive = 1'b0;
      if (base.seen_dot) begin
        state_next.float_alive = 1'b0;
      end
      state_next.seen_dot = 1'b1;
    end else if (in_data.char_code == CH_MINUS) begin
      if (base.seen_minus) begin
        state_next.int_alive   = 1'b0;
        state_next.float_alive = 1'b0;
      end
      state_next.seen_minus = 1'b1;
    end else if (is_digit) begin
      state_next.digit_count = count_inc;
      if (count_inc > max_int_digits) begin
        state_next.int_alive = 1'b0;
      end
      if (count_inc > max_float_digits) begin
        state_next.float_alive = 1'b0;
      end
    end else if ((in_data.char_code != CH_STAR) && (in_data.char_code != CH_QUESTION)) begin
      state_next.int_alive   = 1'b0;
      state_next.float_alive = 1'b0;
    end

    // Static text: a backslash escapes the following character.
    if (base.escape_pending) begin
      state_next.escape_pending = 1'b0;
    end else if (in_data.char_code == CH_BACKSLASH) begin
      state_next.escape_pending = 1'b1;
    end else if (is_digit) begin
      state_next.static_alive = 1'b0;
    end else if (is_alpha) begin
      state_next.has_letter = 1'b1;
    end

    res_next.maybe_integer     = state_next.int_alive;
    res_next.maybe_float       = state_next.float_alive;
    res_next.maybe_static_text = state_next.static_alive &&
                                 !(state_next.equals_before &&
                                   state_next.first_is_question &&
                                   state_next.has_letter);
    res_next.maybe_dictionary  = 1'b1;
    res_next.starts_with_star  = state_next.first_is_star;
    res_next.ends_with_star    = (in_data.char_code == CH_STAR);
    res_next.interpretation_count = 3'(res_next.maybe_integer) +
                                    3'(res_next.maybe_float) +
                                    3'(res_next.maybe_static_text) + 3'd1;
  end

  // Token state: the last character closes the token.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else if (in_advance) begin
      state <= in_data.is_last ? STATE_CLEAR : state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_advance && in_data.is_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && in_data.is_last) begin
      out_data <= res_next;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

`ifndef NO_ASSERTIONS
  // A finished token always leaves the block with no token open.
  a_close_on_last: assert property (@(posedge clk) disable iff (rst)
    (in_advance && in_data.is_last) |=> !state.in_token)
    else $error("token state still open after its last character");

  // The count matches the listed interpretations, dictionary included.
  a_count_consistent: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.data.maybe_dictionary &&
      (result.data.interpretation_count ==
       3'(result.data.maybe_integer) + 3'(result.data.maybe_float) +
       3'(result.data.maybe_static_text) + 3'd1)))
    else $error("interpretation count does not match the flags");

  // A last character is held back only while a result is stalled.
  a_last_waits_on_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_data.is_last && !in_advance) |-> (out_valid && !result.ready))
    else $error("last character held without a stalled result");
`endif

endmodule

@@ dv/wildcard_token_classifier_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the wildcard token classifier: random tokens, checked results.
module wildcard_token_classifier_test;
  import wtc_pkg::*;

  // The package has no constant for '=', which matters to the static text rule.
  localparam logic [7:0] CH_EQUALS = 8'h3D;

  // The block holds a character in its input register and a result in its
  // result register. SETTLE covers the input register, which may still be
  // busy after the last result.
  localparam int SETTLE = 4;

  localparam int CYCLE_LIMIT = 200000;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 85;

  // Tracks the open token the same way the block does. Every accepted character
  // goes through take_char, and a last character leaves the classification it
  // must produce in expected_classes. Results from the block are compared
  // against that queue in arrival order.
  class token_classes;
    logic [CFG_W-1:0]   int_limit;
    logic [CFG_W-1:0]   float_limit;
    bit                 int_ok;
    bit                 float_ok;
    bit                 static_ok;
    bit                 minus_seen;
    bit                 dot_seen;
    bit                 esc_pending;
    bit                 letter_seen;
    bit                 lead_question;
    bit                 lead_star;
    bit                 eq_before;
    bit                 token_open;
    logic [DIGIT_W-1:0] digits;
    result_t            expected_classes[$];
    int                 mismatches;

    function new();
      int_limit   = MAX_INT_RESET;
      float_limit = MAX_FLOAT_RESET;
      mismatches  = 0;
      clear_token();
    endfunction

    function void clear_token();
      int_ok        = 1'b1;
      float_ok      = 1'b1;
      static_ok     = 1'b1;
      minus_seen    = 1'b0;
      dot_seen      = 1'b0;
      esc_pending   = 1'b0;
      letter_seen   = 1'b0;
      lead_question = 1'b0;
      lead_star     = 1'b0;
      eq_before     = 1'b0;
      token_open    = 1'b0;
      digits        = '0;
    endfunction

    function void set_limit(reg_index_t idx, logic [CFG_W-1:0] value);
      if (idx == REG_MAX_INT_DIGITS) begin
        int_limit = value;
      end else begin
        float_limit = value;
      end
    endfunction

    function void take_char(token_t t);
      logic [7:0] c;
      bit         digit;
      bit         alpha;
      result_t    r;
      c     = t.char_code;
      digit = c >= CH_ZERO && c <= CH_NINE;
      alpha = (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);

      // A first character, or any character while no token is open, starts afresh.
      if (t.is_first || !token_open) begin
        clear_token();
        lead_question = c == CH_QUESTION;
        lead_star     = c == CH_STAR;
        eq_before     = t.after_equals;
        token_open    = 1'b1;
      end

      if (c == CH_DOT) begin
        int_ok = 1'b0;
        if (dot_seen) begin
          float_ok = 1'b0;
        end
        dot_seen = 1'b1;
      end else if (c == CH_MINUS) begin
        if (minus_seen) begin
          int_ok   = 1'b0;
          float_ok = 1'b0;
        end
        minus_seen = 1'b1;
      end else if (digit) begin
        if (digits != DIGIT_SAT) begin
          digits++;
        end
        if (digits > int_limit) begin
          int_ok = 1'b0;
        end
        if (digits > float_limit) begin
          float_ok = 1'b0;
        end
      end else if (c != CH_STAR && c != CH_QUESTION) begin
        int_ok   = 1'b0;
        float_ok = 1'b0;
      end

      // An escaped character is neutral for static text, whatever it is.
      if (esc_pending) begin
        esc_pending = 1'b0;
      end else if (c == CH_BACKSLASH) begin
        esc_pending = 1'b1;
      end else if (digit) begin
        static_ok = 1'b0;
      end else if (alpha) begin
        letter_seen = 1'b1;
      end

      if (t.is_last) begin
        r.maybe_integer        = int_ok;
        r.maybe_float          = float_ok;
        r.maybe_static_text    = static_ok && !(eq_before && lead_question && letter_seen);
        r.maybe_dictionary     = 1'b1;
        r.starts_with_star     = lead_star;
        r.ends_with_star       = c == CH_STAR;
        r.interpretation_count = 3'(int'(r.maybe_integer) + int'(r.maybe_float)
                                    + int'(r.maybe_static_text) + 1);
        expected_classes = {expected_classes, r};
        clear_token();
      end
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_classes(result_t got);
      result_t want;
      if (expected_classes.size() == 0) begin
        $error("result transaction with no classification pending");
        mismatches++;
        return;
      end
      want = expected_classes.pop_front();
      compare_field("maybe_integer", want.maybe_integer, got.maybe_integer);
      compare_field("maybe_float", want.maybe_float, got.maybe_float);
      compare_field("maybe_static_text", want.maybe_static_text, got.maybe_static_text);
      compare_field("maybe_dictionary", want.maybe_dictionary, got.maybe_dictionary);
      compare_field("starts_with_star", want.starts_with_star, got.starts_with_star);
      compare_field("ends_with_star", want.ends_with_star, got.ends_with_star);
      compare_field("interpretation_count", want.interpretation_count,
                    got.interpretation_count);
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_write;
  reg_index_t       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // When this is set, both sides pick a random idle time before every
  // transaction. Some phases clear it to run the channels flat out.
  bit gaps_on;

  token_classes oracle = new();

  wtc_tok_if tok_ch();
  wtc_res_if res_ch();

  wildcard_token_classifier u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .token     (tok_ch),
    .result    (res_ch)
  );

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  // Offers one character and waits for the transaction to complete. Once it
  // is accepted, the character goes straight to the checker from this same
  // process, so the checker is never behind the stimulus. With no gap, valid
  // just stays high for the next character.
  task automatic send_char(logic [7:0] code, bit starts_tok, bit ends_tok, bit eq);
    token_t t;
    int     gap;
    t = '{char_code: code, is_first: starts_tok, is_last: ends_tok, after_equals: eq};
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      tok_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tok_ch.valid <= 1'b1;
    tok_ch.data  <= t;
    do @(posedge clk); while (!tok_ch.ready);
    oracle.take_char(t);
  endtask

  // Sends a complete token given as text. The flag for a preceding '=' is
  // taken from its first character.
  task automatic send_text(string s, bit eq);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == 0, i == s.len() - 1, eq);
    end
  endtask

  // Picks a character for one of four token styles: numeric, text, a run of
  // digits, or any byte at all. Every style also draws an arbitrary byte now
  // and then.
  function automatic logic [7:0] pick_char(int style);
    int r;
    r = $urandom_range(0, 15);
    if (style == 3 || r == 15) begin
      return 8'($urandom_range(0, 255));
    end
    if (style == 2) begin
      return (r == 14) ? CH_MINUS : CH_ZERO + 8'(r % 10);
    end
    if (style == 0) begin
      case (r)
        10: return CH_MINUS;
        11: return CH_DOT;
        12: return CH_STAR;
        13: return CH_QUESTION;
        14: return CH_BACKSLASH;
        default: return CH_ZERO + 8'(r);
      endcase
    end
    case (r)
      6: return CH_BACKSLASH;
      7: return CH_ZERO + 8'($urandom_range(0, 9));
      8: return CH_STAR;
      9: return CH_QUESTION;
      10: return CH_EQUALS;
      11: return CH_MINUS;
      12: return CH_DOT;
      // Characters right next to the letter ranges must not count as letters.
      13: return $urandom_range(0, 1) ? CH_UPPER_A - 8'd1 : CH_UPPER_Z + 8'd1;
      14: return $urandom_range(0, 1) ? CH_LOWER_A - 8'd1 : CH_LOWER_Z + 8'd1;
      default: return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A)
                      + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // Sends one random token. Most tokens are short. About one in eight is longer,
  // up to 36 characters, so it can run past the digit limits and into the point
  // where the counter saturates. Leaving out the last character gives a broken
  // token, and the next first character cuts it off.
  task automatic send_token(bit closed, inout int items);
    int         len;
    int         style;
    logic [7:0] c;
    style = $urandom_range(0, 3);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 36) : $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      c = pick_char(style);
      if (i == 0 && $urandom_range(0, 3) == 0) begin
        c = $urandom_range(0, 1) ? CH_QUESTION : CH_STAR;
      end
      send_char(c, i == 0, closed && i == len - 1, $urandom_range(0, 1));
      items++;
    end
  endtask

  // Holds the token channel until every pending result has been delivered,
  // then lets the pipeline settle. Configuration writes always come after it.
  task automatic drain_results();
    tok_ch.valid <= 1'b0;
    while (oracle.expected_classes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes the integer limit and then the float limit, keeping the write enable
  // high across both writes.
  task automatic configure(logic [CFG_W-1:0] int_lim, logic [CFG_W-1:0] float_lim);
    cfg_write <= 1'b1;
    cfg_index <= REG_MAX_INT_DIGITS;
    cfg_data  <= int_lim;
    @(posedge clk);
    cfg_index <= REG_MAX_FLOAT_DIGITS;
    cfg_data  <= float_lim;
    @(posedge clk);
    cfg_write <= 1'b0;
    oracle.set_limit(REG_MAX_INT_DIGITS, int_lim);
    oracle.set_limit(REG_MAX_FLOAT_DIGITS, float_lim);
  endtask

  // Result side. While gaps are on, it stalls for a random time before each
  // transaction; then it holds ready high until a result arrives and checks it.
  initial begin : result_sink
    int stall;
    res_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = gaps_on ? $urandom_range(0, 7) : 0;
      repeat (stall) begin
        res_ch.ready <= 1'b0;
        @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      oracle.check_classes(res_ch.data);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int items;
    int goal;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = REG_MAX_INT_DIGITS;
    cfg_data     = '0;
    tok_ch.valid = 1'b0;
    tok_ch.data  = '0;
    gaps_on      = 1'b1;
    items        = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed tokens, run with the limits at their reset values.
    // A lone '*' both starts and ends with a star.
    send_text("*", 1'b0);
    // With '=' before it, a token that starts with '?' and holds a letter
    // cannot be static text.
    send_text("?ab", 1'b1);
    // A float with a sign and a trailing wildcard. Because of the dot, it
    // cannot be an integer.
    send_text("-1.5*", 1'b0);
    // An escaped digit leaves static text possible, but the backslash itself
    // rules out both numbers.
    send_text("\\9", 1'b0);
    // A second minus or a second dot kills the numeric readings.
    send_text("--", 1'b0);
    send_text("..", 1'b0);
    // The highest and lowest byte values, each a token of one character.
    send_char(8'hFF, 1'b1, 1'b1, 1'b1);
    send_char(8'h00, 1'b1, 1'b1, 1'b0);
    // No first flag, but no token is open, so this character starts one.
    send_char(CH_UPPER_Z, 1'b0, 1'b1, 1'b0);
    // An escape still pending when the token ends is dropped.
    send_text("a\\", 1'b0);
    // A new first character in the middle of a token throws the old one away.
    send_char(CH_ZERO + 8'd1, 1'b1, 1'b0, 1'b0);
    send_char(CH_ZERO + 8'd2, 1'b0, 1'b0, 1'b0);
    send_char(CH_QUESTION, 1'b1, 1'b1, 1'b1);
    drain_results();

    // Random phases. Each one starts from an idle block with new digit limits:
    // the extremes first, then the common settings, then random values.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(5'd1, 5'd1);
        1: configure(5'd30, 5'd30);
        2: configure(5'd0, 5'd31);
        3: configure(5'd31, 5'd0);
        4: configure(5'd10, 5'd19);
        default: configure(5'($urandom_range(1, 30)), 5'($urandom_range(1, 30)));
      endcase
      gaps_on = (p % 3) != 1;
      goal = items + PHASE_ITEMS;
      while (items < goal) begin
        case ($urandom_range(0, 11))
          0: begin
            // A stray character with random flags.
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 1),
                      $urandom_range(0, 1), $urandom_range(0, 1));
            items++;
          end
          1: send_token(1'b0, items);
          2: drain_results();
          default: send_token(1'b1, items);
        endcase
      end
      // A closing character makes sure no token is left open before the next
      // set of limits is written.
      send_char(pick_char(3), $urandom_range(0, 1), 1'b1, $urandom_range(0, 1));
      drain_results();
    end

    if (oracle.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
